// ===== sv/lsb_stego_extractor_macros.svh =====
// assertion macros for the lsb stego extractor checker
// expects clk and rst to be visible where a macro is used
`ifndef LSB_STEGO_EXTRACTOR_MACROS_SVH
`define LSB_STEGO_EXTRACTOR_MACROS_SVH

// checked only while out of reset
`define LSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define LSE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/lse_pkg.sv =====
// shared types and constants for the lsb stego extractor
// no dependencies
package lse_pkg;

  localparam int MAX_ROW_BYTES = 16384;
  localparam int LENGTH_BITS   = 32;
  localparam int ROW_ALIGN     = 4;
  localparam int ROW_W         = 15;
  localparam int BPB_W         = 4;
  localparam int CFG_DATA_W    = 15;
  localparam int HSEEN_W       = 6;
  localparam int BITS_MAX      = 8;

  typedef enum logic [0:0] {
    CFG_ROW_BYTES     = 1'b0,
    CFG_BITS_PER_BYTE = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       start_of_image;
  } in_word_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
  } out_word_t;

  // clamped configuration handed to the extraction logic
  typedef struct packed {
    logic [ROW_W-1:0] data_len;
    logic [ROW_W-1:0] row_total;
    logic [BPB_W-1:0] hidden_bits;
  } cfg_eff_t;

endpackage

// ===== sv/lse_cfg_regs.sv =====
// configuration registers and their clamped working values
// depends on lse_pkg
module lse_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  lse_pkg::cfg_index_t           cfg_index,
  input  logic [lse_pkg::CFG_DATA_W-1:0] cfg_data,
  output lse_pkg::cfg_eff_t             eff
);

  localparam logic [lse_pkg::ROW_W-1:0] ROW_MAX   = lse_pkg::ROW_W'(lse_pkg::MAX_ROW_BYTES);
  localparam logic [lse_pkg::ROW_W:0]   ALIGN_M1  = (lse_pkg::ROW_W+1)'(lse_pkg::ROW_ALIGN - 1);
  localparam int                        ALIGN_LOG = $clog2(lse_pkg::ROW_ALIGN);
  localparam logic [lse_pkg::BPB_W-1:0] BITS_TOP  = lse_pkg::BPB_W'(lse_pkg::BITS_MAX);

  logic [lse_pkg::ROW_W-1:0] row_bytes;
  logic [lse_pkg::BPB_W-1:0] bits_per_byte;
  logic [lse_pkg::ROW_W-1:0] data_len;
  logic [lse_pkg::ROW_W:0]   round_sum;
  logic [lse_pkg::ROW_W:0]   round_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes     <= lse_pkg::ROW_W'(1);
      bits_per_byte <= lse_pkg::BPB_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        lse_pkg::CFG_ROW_BYTES:     row_bytes     <= cfg_data[lse_pkg::ROW_W-1:0];
        lse_pkg::CFG_BITS_PER_BYTE: bits_per_byte <= cfg_data[lse_pkg::BPB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (row_bytes == '0) begin
      data_len = lse_pkg::ROW_W'(1);
    end else if (row_bytes > ROW_MAX) begin
      data_len = ROW_MAX;
    end else begin
      data_len = row_bytes;
    end
    // round up to the row alignment
    round_sum = {1'b0, data_len} + ALIGN_M1;
    round_up  = (round_sum >> ALIGN_LOG) << ALIGN_LOG;
    eff.data_len    = data_len;
    eff.row_total   = round_up[lse_pkg::ROW_W-1:0];
    eff.hidden_bits = (bits_per_byte > BITS_TOP) ? BITS_TOP : bits_per_byte;
  end

endmodule

// ===== sv/lse_extract.sv =====
// extraction state and the per-byte update: row tracking, length header, bit packing
// depends on lse_pkg
module lse_extract (
  input  logic               clk,
  input  logic               rst,
  input  lse_pkg::cfg_eff_t  eff,
  input  logic               step,
  input  lse_pkg::in_word_t  item,
  output logic               res_valid,
  output lse_pkg::out_word_t res
);

  localparam logic [lse_pkg::HSEEN_W-1:0] LEN_BITS = lse_pkg::HSEEN_W'(lse_pkg::LENGTH_BITS);

  function automatic logic [7:0] low_mask8(input logic [3:0] n);
    logic [8:0] m;
    m = (9'd1 << n) - 9'd1;
    return m[7:0];
  endfunction

  // state
  logic [14:0]                  bit_buffer;
  logic [3:0]                   buffered_bits;
  logic [31:0]                  payload_length;
  logic [lse_pkg::HSEEN_W-1:0]  header_bits_seen;
  logic [31:0]                  bytes_emitted;
  logic [lse_pkg::ROW_W-1:0]    row_position;
  logic                         finished;

  logic [14:0]                  bit_buffer_next;
  logic [3:0]                   buffered_bits_next;
  logic [31:0]                  payload_length_next;
  logic [lse_pkg::HSEEN_W-1:0]  header_bits_seen_next;
  logic [31:0]                  bytes_emitted_next;
  logic [lse_pkg::ROW_W-1:0]    row_position_next;
  logic                         finished_next;

  // state after an optional start-of-image clear
  logic [14:0]                  cur_buf;
  logic [3:0]                   cur_cnt;
  logic [31:0]                  cur_len;
  logic [lse_pkg::HSEEN_W-1:0]  cur_hseen;
  logic [31:0]                  cur_emit;
  logic [lse_pkg::ROW_W-1:0]    cur_pos;
  logic                         cur_fin;

  logic                         take;
  logic [lse_pkg::ROW_W:0]      pos_inc;
  logic [lse_pkg::HSEEN_W-1:0]  room;
  logic [3:0]                   n_hdr;
  logic [3:0]                   n_body;
  logic [7:0]                   hdr_bits;
  logic [7:0]                   body_bits;
  logic [31:0]                  len_upd;
  logic [14:0]                  buf_upd;
  logic [3:0]                   cnt_sum;
  logic [3:0]                   cnt_left;
  logic [14:0]                  buf_aligned;
  logic [14:0]                  keep_mask;
  logic                         emit;
  logic                         last;

  always_comb begin
    if (item.start_of_image) begin
      cur_buf   = '0;
      cur_cnt   = '0;
      cur_len   = '0;
      cur_hseen = '0;
      cur_emit  = '0;
      cur_pos   = '0;
      cur_fin   = 1'b0;
    end else begin
      cur_buf   = bit_buffer;
      cur_cnt   = buffered_bits;
      cur_len   = payload_length;
      cur_hseen = header_bits_seen;
      cur_emit  = bytes_emitted;
      cur_pos   = row_position;
      cur_fin   = finished;
    end

    // row position, pad bytes skipped
    pos_inc = {1'b0, cur_pos} + 1'b1;
    take    = !cur_fin && (cur_pos < eff.data_len);

    // split the hidden bits between the length header and the payload
    room   = LEN_BITS - cur_hseen;
    n_hdr  = ({2'b00, eff.hidden_bits} > room) ? room[3:0] : eff.hidden_bits;
    n_body = eff.hidden_bits - n_hdr;

    hdr_bits  = (item.pixel_byte >> n_body) & low_mask8(n_hdr);
    body_bits = item.pixel_byte & low_mask8(n_body);

    len_upd = (cur_len << n_hdr) | {24'd0, hdr_bits};
    buf_upd = (cur_buf << n_body) | {7'd0, body_bits};
    cnt_sum = cur_cnt + n_body;

    emit        = take && (cnt_sum >= 4'd8);
    buf_aligned = buf_upd >> (cnt_sum - 4'd8);
    cnt_left    = emit ? (cnt_sum - 4'd8) : cnt_sum;
    keep_mask   = (15'd1 << cnt_left) - 15'd1;

    bytes_emitted_next = cur_emit + 32'd1;
    last = (len_upd != '0) && (bytes_emitted_next == len_upd);

    // default: hold (after clear)
    bit_buffer_next       = cur_buf;
    buffered_bits_next    = cur_cnt;
    payload_length_next   = cur_len;
    header_bits_seen_next = cur_hseen;
    row_position_next     = cur_pos;
    finished_next         = cur_fin;
    if (!cur_fin) begin
      row_position_next = (pos_inc >= {1'b0, eff.row_total}) ? '0
                                                             : pos_inc[lse_pkg::ROW_W-1:0];
    end
    if (take) begin
      payload_length_next   = len_upd;
      header_bits_seen_next = cur_hseen + {2'b00, n_hdr};
      buffered_bits_next    = cnt_left;
      bit_buffer_next       = emit ? (buf_upd & keep_mask) : buf_upd;
    end
    if (!emit) begin
      bytes_emitted_next = cur_emit;
    end
    if (emit && last) begin
      finished_next = 1'b1;
    end

    res_valid        = step && emit;
    res.payload_byte = buf_aligned[7:0];
    res.last_byte    = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer       <= '0;
      buffered_bits    <= '0;
      payload_length   <= '0;
      header_bits_seen <= '0;
      bytes_emitted    <= '0;
      row_position     <= '0;
      finished         <= 1'b0;
    end else if (step) begin
      bit_buffer       <= bit_buffer_next;
      buffered_bits    <= buffered_bits_next;
      payload_length   <= payload_length_next;
      header_bits_seen <= header_bits_seen_next;
      bytes_emitted    <= bytes_emitted_next;
      row_position     <= row_position_next;
      finished         <= finished_next;
    end
  end

endmodule

// ===== sv/lsb_stego_extractor.sv =====
// lsb stego extractor top level: input register, extraction update, result register
// depends on lse_pkg, lse_cfg_regs, lse_extract
//
// Takes one BMP pixel-array byte per word (row padding included) and recovers the
// payload hidden in the low bits_per_byte bits of each data byte, msb first. The first
// 32 hidden bits are a big-endian byte count; every later group of 8 bits comes out as
// one payload word, and the word that reaches the count has last_byte set, after which
// input words are swallowed until one arrives with start_of_image. A count of zero
// never ends. start_of_image clears all extraction state and that byte counts as the
// first byte of row 0. Throughput is one input word per clock while the result
// register is not stalled. A word waits in the input register until it is
// processed, and its result (if it makes one) is registered in the result register
// as it is processed. The only loop is the extraction state update, so back-to-back
// words see the state left by the one before. in_stall rises only when the result
// register is full and stalled while an input word is waiting.
// Configuration (row_bytes, bits_per_byte) is written through cfg_we/cfg_index/
// cfg_data and must only change while no word is in flight.
module lsb_stego_extractor (
  input  logic                           clk,
  input  logic                           rst,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  lse_pkg::in_word_t              in_word,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output lse_pkg::out_word_t             out_word,
  // configuration write port
  input  logic                           cfg_we,
  input  lse_pkg::cfg_index_t            cfg_index,
  input  logic [lse_pkg::CFG_DATA_W-1:0] cfg_data
);

  lse_pkg::cfg_eff_t  eff;
  logic               in_take;
  logic               hold_valid;
  lse_pkg::in_word_t  hold_word;
  logic               hold_go;
  logic               res_valid;
  lse_pkg::out_word_t res;

  lse_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .eff       (eff)
  );

  // the held word moves on unless a finished result is stuck in the output
  assign hold_go  = hold_valid && !(out_valid && out_stall);
  assign in_stall = hold_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_take) begin
      hold_valid <= 1'b1;
    end else if (hold_go) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_word <= in_word;
    end
  end

  // extraction state and per-word update
  lse_extract u_extract (
    .clk       (clk),
    .rst       (rst),
    .eff       (eff),
    .step      (hold_go),
    .item      (hold_word),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_word <= res;
    end
  end

endmodule

// ===== sv/lse_checker.sv =====
// port-level checks for the lsb stego extractor, bound to the top level
// depends on lse_pkg and lsb_stego_extractor_macros.svh
`include "lsb_stego_extractor_macros.svh"

module lse_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input lse_pkg::out_word_t             out_word
);

  // a stalled result word holds
  `LSE_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_word)), "result word changed while stalled")

  // nothing comes out right after reset
  `LSE_ASSERT_ALWAYS(a_reset_clear, rst |=> !out_valid, "result valid right after reset")

  // input back-pressure only comes from a stuck result
  `LSE_ASSERT(a_stall_cause, in_stall |-> (out_valid && out_stall), "input stalled without a stuck result")

  // a fresh result follows a word taken straight through both registers
  `LSE_ASSERT(a_latency, $rose(out_valid) |-> $past(in_valid && !in_stall, 2), "result without a matching input word")

endmodule

bind lsb_stego_extractor lse_checker u_lse_checker (.*);
